@@ hw/rtl/lennard_jones_pair_energy_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Lennard-Jones pair energy unit assertion macros
// Implication checks clocked on a rising edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LENNARD_JONES_PAIR_ENERGY_UNIT_ASSERT_SVH
`define LENNARD_JONES_PAIR_ENERGY_UNIT_ASSERT_SVH

// same-cycle implication
`define LJ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("lj pair energy: check failed");

// next-cycle implication
`define LJ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lj pair energy: check failed");

`endif

@@ hw/rtl/lj_pkg.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones pair energy package
// Register codes, reset values and the divider stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package lj_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;
	localparam int QUO_W = 48;
	localparam int CUBE_W = 96;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_LENGTH = 8'd0,
		REG_CUTOFF_SQ = 8'd1,
		REG_FOUR_EPSILON = 8'd2,
		REG_SIGMA_SIXTH = 8'd3
	} lj_reg_t;

	localparam logic [23:0] BOX_RESET = 24'd2326528;
	localparam logic [31:0] CUTOFF_RESET = 32'd6553600;
	localparam logic [23:0] FEPS_RESET = 24'd14149917;
	localparam logic [27:0] SIGMA_RESET = 28'd91802956;

	typedef struct packed {
		logic vld;
		logic near;
		logic big;
		logic [CUBE_W-1:0] dvs;
		logic [CUBE_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} lj_div_t;

endpackage

`default_nettype wire

@@ hw/rtl/lj_if.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones pair energy channels
// Pair input, energy result and configuration write interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface lj_pair_if #(parameter int COORD_WIDTH = 24);
	logic valid;
	logic ready;
	logic [COORD_WIDTH-1:0] first_x;
	logic [COORD_WIDTH-1:0] first_y;
	logic [COORD_WIDTH-1:0] first_z;
	logic [COORD_WIDTH-1:0] second_x;
	logic [COORD_WIDTH-1:0] second_y;
	logic [COORD_WIDTH-1:0] second_z;
	logic same_atom;
	modport source (output valid, first_x, first_y, first_z, second_x, second_y,
		second_z, same_atom, input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y,
		second_z, same_atom, output ready);
endinterface

interface lj_energy_if;
	logic valid;
	logic ready;
	logic signed [31:0] pair_energy;
	logic in_cutoff;
	logic saturated;
	modport source (output valid, pair_energy, in_cutoff, saturated, input ready);
	modport sink (input valid, pair_energy, in_cutoff, saturated, output ready);
endinterface

interface lj_cfg_if;
	logic valid;
	logic ready;
	logic [lj_pkg::CFG_IDX_W-1:0] index;
	logic [lj_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lennard_jones_pair_energy_unit.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones 12-6 pair energy unit
// Minimum-image distance, cutoff test and saturated Q8.24 pair energy.
// ----------------------------------------------------------------------------
// Usage:
//   pairs  : one atom pair per transfer (valid/ready), coordinates Q8.16.
//   energy : one result per pair, in input order: pair_energy (Q8.24),
//            in_cutoff, saturated.
//   cfg    : register writes (index, data); always ready, take effect at once.
//            Write only while no pair is in flight.
// Throughput: one pair per cycle while results are read; see Stall below.
// Pipeline: the 48-stage restoring divider forms sigma6/d^6, one quotient bit
//   per stage, between seven front stages and six back stages of multiply
//   and add.
// Stall: while a result waits unread the whole pipeline holds; pairs.ready
//   drops and nothing is lost or repeated.
// Reset: clears all stage valids and loads register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lennard_jones_pair_energy_unit_assert.svh"

module lennard_jones_pair_energy_unit #(
	parameter int COORD_WIDTH = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	lj_cfg_if.sink cfg,
	lj_pair_if.sink pairs,
	lj_energy_if.source energy
);

	localparam int QW = lj_pkg::QUO_W;
	localparam int CW = lj_pkg::CUBE_W;

	logic [23:0] box_q;
	logic [31:0] cutoff_q;
	logic [23:0] feps_q;
	logic [27:0] sigma_q;

	logic en;
	logic [47:0] sx_s2, sy_s2, sz_s2;
	logic fx_s2, fy_s2, fz_s2;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic same_s1, same_s2;
	logic near_s3, near_s4, near_s5, near_s6;
	logic [31:0] dist2_s3, dist2_s4;
	logic [63:0] d2sq_s4;
	logic [63:0] clo_s5, chi_s5;
	logic [CW-1:0] cube_s6;
	lj_pkg::lj_div_t div_pipe [0:QW];

	logic vld_s56, vld_s57, vld_s58, vld_s59, vld_s60, vld_s61;
	logic near_s56, near_s57, near_s58, near_s59, near_s60;
	logic big_s56, big_s57, big_s58, big_s59, big_s60;
	logic [QW-1:0] s_s56, s_s57;
	logic [31:0] phh_s56;
	logic [48:0] phl_s56;
	logic [63:0] pll_s56;
	logic [63:0] s2_s57;
	logic pos_s58, pos_s59, pos_s60;
	logic [63:0] mag_s58;
	logic [55:0] mlo_s59, mhi_s59;
	logic [87:0] prod_s60;
	logic signed [31:0] energy_s61;
	logic cut_s61, sat_s61;

	logic [49:0] sum3;
	logic [CW-1:0] sig_ext;
	logic [95:0] sq_full;
	logic [87:0] rnd;
	logic signed [31:0] energy_n;
	logic sat_n;

	assign en = !vld_s61 || energy.ready;
	assign pairs.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= lj_pkg::BOX_RESET;
			cutoff_q <= lj_pkg::CUTOFF_RESET;
			feps_q <= lj_pkg::FEPS_RESET;
			sigma_q <= lj_pkg::SIGMA_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lj_pkg::REG_BOX_LENGTH: box_q <= cfg.data[23:0];
				lj_pkg::REG_CUTOFF_SQ: cutoff_q <= cfg.data;
				lj_pkg::REG_FOUR_EPSILON: feps_q <= cfg.data[23:0];
				lj_pkg::REG_SIGMA_SIXTH: sigma_q <= cfg.data[27:0];
				default: ;
			endcase
		end
	end

	lj_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (.clk(clk), .en(en),
		.a(pairs.first_x), .b(pairs.second_x), .box(box_q), .sq_s2(sx_s2), .far_s2(fx_s2));
	lj_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (.clk(clk), .en(en),
		.a(pairs.first_y), .b(pairs.second_y), .box(box_q), .sq_s2(sy_s2), .far_s2(fy_s2));
	lj_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_z (.clk(clk), .en(en),
		.a(pairs.first_z), .b(pairs.second_z), .box(box_q), .sq_s2(sz_s2), .far_s2(fz_s2));

	always_comb begin
		sum3 = {2'b00, sx_s2} + {2'b00, sy_s2} + {2'b00, sz_s2};
		sig_ext = {{(CW-44){1'b0}}, sigma_q, 16'd0};
		sq_full = {phh_s56, 64'd0} + {15'd0, phl_s56, 32'd0} + {32'd0, pll_s56};
		rnd = prod_s60 + 88'hFFFFFFFF;
		energy_n = 32'sd0;
		sat_n = 1'b0;
		priority if (!near_s60 || feps_q == 24'd0) begin
			energy_n = 32'sd0;
		end else if (big_s60) begin
			energy_n = 32'sh7FFFFFFF;
			sat_n = 1'b1;
		end else if (pos_s60) begin
			if (|prod_s60[87:63]) begin
				energy_n = 32'sh7FFFFFFF;
				sat_n = 1'b1;
			end else begin
				energy_n = $signed({1'b0, prod_s60[62:32]});
			end
		end else begin
			energy_n = -$signed(rnd[63:32]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			div_pipe[0] <= '0;
			vld_s56 <= 1'b0;
			vld_s57 <= 1'b0;
			vld_s58 <= 1'b0;
			vld_s59 <= 1'b0;
			vld_s60 <= 1'b0;
			vld_s61 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pairs.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			div_pipe[0].vld <= vld_s6;
			div_pipe[0].near <= near_s6;
			div_pipe[0].big <= cube_s6 <= sig_ext;
			div_pipe[0].dvs <= cube_s6;
			div_pipe[0].rem <= sig_ext;
			div_pipe[0].quo <= '0;
			vld_s56 <= div_pipe[QW].vld;
			vld_s57 <= vld_s56;
			vld_s58 <= vld_s57;
			vld_s59 <= vld_s58;
			vld_s60 <= vld_s59;
			vld_s61 <= vld_s60;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			same_s1 <= pairs.same_atom;
			same_s2 <= same_s1;
			dist2_s3 <= sum3[47:16];
			near_s3 <= !(fx_s2 || fy_s2 || fz_s2) && !same_s2
				&& (sum3[49:16] < {2'b00, cutoff_q});
			near_s4 <= near_s3;
			dist2_s4 <= dist2_s3;
			d2sq_s4 <= dist2_s3 * dist2_s3;
			near_s5 <= near_s4;
			clo_s5 <= d2sq_s4[31:0] * dist2_s4;
			chi_s5 <= d2sq_s4[63:32] * dist2_s4;
			near_s6 <= near_s5;
			cube_s6 <= {chi_s5, 32'd0} + {32'd0, clo_s5};
			near_s56 <= div_pipe[QW].near;
			big_s56 <= div_pipe[QW].big;
			s_s56 <= div_pipe[QW].quo;
			phh_s56 <= div_pipe[QW].quo[47:32] * div_pipe[QW].quo[47:32];
			phl_s56 <= {1'b0, div_pipe[QW].quo[47:32], 1'b0} * div_pipe[QW].quo[31:0];
			pll_s56 <= div_pipe[QW].quo[31:0] * div_pipe[QW].quo[31:0];
			near_s57 <= near_s56;
			big_s57 <= big_s56;
			s_s57 <= s_s56;
			s2_s57 <= sq_full[95:32];
			near_s58 <= near_s57;
			big_s58 <= big_s57;
			pos_s58 <= s2_s57 >= {16'd0, s_s57};
			mag_s58 <= (s2_s57 >= {16'd0, s_s57}) ? s2_s57 - {16'd0, s_s57}
				: {16'd0, s_s57} - s2_s57;
			near_s59 <= near_s58;
			big_s59 <= big_s58;
			pos_s59 <= pos_s58;
			mlo_s59 <= feps_q * mag_s58[31:0];
			mhi_s59 <= feps_q * mag_s58[63:32];
			near_s60 <= near_s59;
			big_s60 <= big_s59;
			pos_s60 <= pos_s59;
			prod_s60 <= {mhi_s59, 32'd0} + {32'd0, mlo_s59};
			energy_s61 <= energy_n;
			cut_s61 <= near_s60;
			sat_s61 <= sat_n;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_div
		lj_div_step u_step (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.d_in(div_pipe[i]),
			.d_out(div_pipe[i+1])
		);
	end

	assign energy.valid = vld_s61;
	assign energy.pair_energy = energy_s61;
	assign energy.in_cutoff = cut_s61;
	assign energy.saturated = sat_s61;

	`LJ_ASSERT_IMP(a_sat_in_cut, clk, arst_n, vld_s61 && sat_s61, cut_s61)
	`LJ_ASSERT_IMP(a_out_zero, clk, arst_n, vld_s61 && !cut_s61,
		energy_s61 == 32'sd0 && !sat_s61)
	`LJ_ASSERT_NXT(a_take_in, clk, arst_n, pairs.valid && pairs.ready, vld_s1)

endmodule

`default_nettype wire

@@ hw/rtl/lj_axis.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones axis difference
// Two stages: minimum-image wrap, then magnitude check and square.
// ----------------------------------------------------------------------------
`default_nettype none

module lj_axis #(
	parameter int COORD_WIDTH = 24
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [COORD_WIDTH-1:0] a,
	input wire logic [COORD_WIDTH-1:0] b,
	input wire logic [23:0] box,
	output logic [47:0] sq_s2,
	output logic far_s2
);

	localparam int DW = ((COORD_WIDTH > 24) ? COORD_WIDTH : 24) + 2;

	logic signed [DW-1:0] d, d2, box_s, dw, dw_s1;
	logic [DW-1:0] mag;

	always_comb begin
		d = $signed({{(DW-COORD_WIDTH){1'b0}}, a}) - $signed({{(DW-COORD_WIDTH){1'b0}}, b});
		d2 = d <<< 1;
		box_s = $signed({{(DW-24){1'b0}}, box});
		priority if (d2 < -box_s) begin
			dw = d + box_s;
		end else if (d2 > box_s) begin
			dw = d - box_s;
		end else begin
			dw = d;
		end
		mag = dw_s1[DW-1] ? $unsigned(-dw_s1) : $unsigned(dw_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dw_s1 <= dw;
			sq_s2 <= mag[23:0] * mag[23:0];
			far_s2 <= |mag[DW-1:24];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lj_div_step.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones divider step
// One restoring quotient bit per stage, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lj_div_step (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire lj_pkg::lj_div_t d_in,
	output lj_pkg::lj_div_t d_out
);

	logic [lj_pkg::CUBE_W:0] t, diff;
	logic ge;

	always_comb begin
		t = {d_in.rem, 1'b0};
		diff = t - {1'b0, d_in.dvs};
		ge = t >= {1'b0, d_in.dvs};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out.vld <= d_in.vld;
			d_out.near <= d_in.near;
			d_out.big <= d_in.big;
			d_out.dvs <= d_in.dvs;
			d_out.rem <= ge ? diff[lj_pkg::CUBE_W-1:0] : t[lj_pkg::CUBE_W-1:0];
			d_out.quo <= {d_in.quo[lj_pkg::QUO_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire
